FILE: sv/stul_pkg.sv
// Shared types, constants and helpers for the source table update/lookup block.
// Used by stul_fnv, stul_cell, source_table_update_lookup_core and stul_checker.
package stul_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int FNV_ROUNDS = 14;
    localparam int RND_W      = $clog2(FNV_ROUNDS + 1);

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [31:0] STREAM_MIX = 32'h9e3779b9;

    localparam logic [31:0] BEACON_MAGIC   = 32'h44554152;
    localparam logic [7:0]  BEACON_VERSION = 8'h01;
    localparam logic [7:0]  BEACON_TYPE    = 8'h01;

    // Configuration register indexes and reset values
    localparam logic [1:0]  REG_FRAME_US  = 2'd0;
    localparam logic [1:0]  REG_RATE_HZ   = 2'd1;
    localparam logic [1:0]  REG_FRAME_LEN = 2'd2;
    localparam logic [15:0] RST_FRAME_US  = 16'd7500;
    localparam logic [15:0] RST_RATE_HZ   = 16'd48000;
    localparam logic [7:0]  RST_FRAME_LEN = 8'd144;

    // Operation codes
    localparam logic [1:0] OP_BEACON = 2'd0;
    localparam logic [1:0] OP_JOIN   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_REJECTED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [47:0]        addr;
        logic [63:0]        room;
        logic [47:0]        seen;
        logic signed [7:0]  level;
        logic [31:0]        code;
        logic [31:0]        stream;
    } t_entry;

    typedef struct packed {
        logic [47:0] addr;
        logic [63:0] room;
        logic [31:0] stream;
        logic [31:0] code;
    } t_query;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             empty;
        logic [IDX_W-1:0] empty_idx;
        logic             old;
        logic [IDX_W-1:0] old_idx;
        logic [47:0]      old_time;
        logic             join_hit;
        logic [IDX_W-1:0] join_idx;
    } t_scan;

    typedef struct packed {
        logic             we;
        logic             clr;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wr;

    // Rooms match on all bytes up to and including the first zero byte
    function automatic logic rooms_match(input logic [63:0] a, input logic [63:0] b);
        logic match;
        logic done;
        match = 1'b1;
        done  = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!done) begin
                if (a[8*i +: 8] != b[8*i +: 8]) begin
                    match = 1'b0;
                    done  = 1'b1;
                end else if (a[8*i +: 8] == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return match;
    endfunction

endpackage

FILE: sv/stul_fnv.sv
// Iterative FNV-1a-32 over eight room bytes then six address bytes, one byte a cycle.
// Depends on stul_pkg.
module stul_fnv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_room,
    input  logic [47:0] i_addr,
    output logic        o_busy,
    output logic [31:0] o_hash
);
    import stul_pkg::*;

    logic [111:0]     r_bytes;
    logic [RND_W-1:0] r_cnt;
    logic [31:0]      r_hash;
    logic [31:0]      w_mix;
    logic [31:0]      n_hash;

    assign w_mix  = r_hash ^ {24'd0, r_bytes[111:104]};
    assign n_hash = w_mix * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt   <= RND_W'(FNV_ROUNDS);
            r_hash  <= FNV_BASIS;
            r_bytes <= {i_room, i_addr};
        end else if (r_cnt != '0) begin
            r_cnt   <= r_cnt - 1'b1;
            r_hash  <= n_hash;
            r_bytes <= {r_bytes[103:0], 8'd0};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_hash = r_hash;

endmodule

FILE: sv/stul_cell.sv
// One table entry plus its stage of the search chain.
// Depends on stul_pkg.
module stul_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [stul_pkg::IDX_W-1:0] i_idx,
    input  stul_pkg::t_query       i_query,
    input  logic                   i_tok,
    input  stul_pkg::t_scan        i_scan,
    input  stul_pkg::t_wr          i_wr,
    output logic                   o_tok,
    output stul_pkg::t_scan        o_scan,
    output stul_pkg::t_entry       o_entry
);
    import stul_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   r_tok;
    t_scan  r_scan;
    t_scan  n_scan;
    logic   w_hit;
    logic   w_join;

    assign w_hit  = r_valid && (r_entry.addr == i_query.addr)
                    && rooms_match(r_entry.room, i_query.room);
    assign w_join = r_valid && ((r_entry.addr == i_query.addr)
                    || (r_entry.stream == i_query.stream)
                    || (r_entry.code == i_query.code));

    always_comb begin
        n_scan = i_scan;
        if (!i_scan.hit && w_hit) begin
            n_scan.hit     = 1'b1;
            n_scan.hit_idx = i_idx;
        end
        if (!i_scan.empty && !r_valid) begin
            n_scan.empty     = 1'b1;
            n_scan.empty_idx = i_idx;
        end
        // strict compare keeps the lowest index on a tie
        if (r_valid && (!i_scan.old || (r_entry.seen < i_scan.old_time))) begin
            n_scan.old      = 1'b1;
            n_scan.old_idx  = i_idx;
            n_scan.old_time = r_entry.seen;
        end
        if (!i_scan.join_hit && w_join) begin
            n_scan.join_hit = 1'b1;
            n_scan.join_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_wr.clr) begin
                r_valid <= 1'b0;
            end else if (i_wr.we && (i_wr.idx == i_idx)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_scan <= n_scan;
        end
        if (i_wr.we && (i_wr.idx == i_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_tok   = r_tok;
    assign o_scan  = r_scan;
    assign o_entry = r_entry;

endmodule

FILE: sv/source_table_update_lookup_core.sv
// Top level of the source table: beacon check, cell chain, hash unit and result register.
// Depends on stul_pkg, stul_cell and stul_fnv.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  command  | start / busy         | i_op, i_src_addr, i_room_id, ... i_beacon_flags
//  result   | o_valid (one cycle)  | o_status, o_slot, o_entry_*, o_valid_count
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A command beat reaches its result strobe once both the byte-serial hash unit and the
// walk along the cell chain are done; with eight entries the hash unit is the slower.
// busy stays high from the accepting edge until the result beat is shown.
// Reset (synchronous, active low) empties the table and loads the default configuration.
// The receiver cannot stall: the result is shown for exactly one cycle.
module source_table_update_lookup_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [47:0]        i_src_addr,
    input  logic [63:0]        i_room_id,
    input  logic [31:0]        i_beacon_stream,
    input  logic [31:0]        i_lookup_code,
    input  logic [47:0]        i_now_us,
    input  logic signed [7:0]  i_signal_level,
    input  logic [47:0]        i_header,
    input  logic [15:0]        i_frame_us,
    input  logic [15:0]        i_rate_hz,
    input  logic [7:0]         i_frame_size,
    input  logic [7:0]         i_beacon_flags,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // result channel
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [2:0]         o_slot,
    output logic [47:0]        o_entry_addr,
    output logic [63:0]        o_entry_room,
    output logic [31:0]        o_entry_code,
    output logic [31:0]        o_entry_stream,
    output logic signed [7:0]  o_entry_level,
    output logic [3:0]         o_valid_count
);
    import stul_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state           r_state;
    t_query           r_query;
    logic [1:0]       r_op;
    logic             r_ok;
    logic [47:0]      r_now;
    logic signed [7:0] r_level;
    logic             r_launch;
    logic             r_scan_done;
    logic [CNT_W-1:0] r_count;

    logic [15:0]      r_cfg_frame_us;
    logic [15:0]      r_cfg_rate_hz;
    logic [7:0]       r_cfg_frame_len;

    logic             w_accept;
    logic             w_beacon_ok;
    logic             w_fnv_busy;
    logic [31:0]      w_fnv_hash;
    t_scan            w_scan  [ENTRIES+1];
    logic             w_tok   [ENTRIES+1];
    t_entry           w_entry [ENTRIES];
    t_wr              w_wr;

    logic [IDX_W-1:0] n_sel;
    logic             n_fresh;
    logic [31:0]      n_code;
    logic [31:0]      n_mix;
    logic [31:0]      n_stream;
    t_entry           n_new;
    t_entry           n_found;
    logic [CNT_W-1:0] n_count;
    logic [2:0]       n_status;
    logic [2:0]       n_slot;
    t_entry           n_out;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // Beacon gate: header fields, configured timing and the ready flag
    assign w_beacon_ok = (i_header[47:16] == BEACON_MAGIC)
                      && (i_header[15:8] == BEACON_VERSION)
                      && (i_header[7:0] == BEACON_TYPE)
                      && (i_frame_us == r_cfg_frame_us)
                      && (i_rate_hz == r_cfg_rate_hz)
                      && (i_frame_size == r_cfg_frame_len)
                      && i_beacon_flags[0];

    // Configuration registers: take the write beat at once, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frame_us  <= RST_FRAME_US;
            r_cfg_rate_hz   <= RST_RATE_HZ;
            r_cfg_frame_len <= RST_FRAME_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_US:  r_cfg_frame_us  <= i_cfg_data;
                REG_RATE_HZ:   r_cfg_rate_hz   <= i_cfg_data;
                REG_FRAME_LEN: r_cfg_frame_len <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Room code runs alongside the walk
    stul_fnv u_fnv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_room  (i_room_id),
        .i_addr  (i_src_addr),
        .o_busy  (w_fnv_busy),
        .o_hash  (w_fnv_hash)
    );

    // Cell chain: the search token advances one entry per cycle
    assign w_scan[0] = '0;
    assign w_tok[0]  = r_launch;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        stul_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(k)),
            .i_query (r_query),
            .i_tok   (w_tok[k]),
            .i_scan  (w_scan[k]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[k+1]),
            .o_scan  (w_scan[k+1]),
            .o_entry (w_entry[k])
        );
    end

    // Finish: pick the entry, build the stored values and the result
    always_comb begin
        // matching entry first, then the lowest free one, then the oldest
        if (w_scan[ENTRIES].hit) begin
            n_sel = w_scan[ENTRIES].hit_idx;
        end else if (w_scan[ENTRIES].empty) begin
            n_sel = w_scan[ENTRIES].empty_idx;
        end else begin
            n_sel = w_scan[ENTRIES].old_idx;
        end
        n_fresh  = !w_scan[ENTRIES].hit && w_scan[ENTRIES].empty;

        n_code   = (w_fnv_hash == 32'd0) ? 32'd1 : w_fnv_hash;
        n_mix    = n_code ^ STREAM_MIX;
        if (r_query.stream != 32'd0) begin
            n_stream = r_query.stream;
        end else begin
            n_stream = (n_mix == 32'd0) ? 32'd1 : n_mix;
        end

        n_new.addr   = r_query.addr;
        n_new.room   = r_query.room;
        n_new.seen   = r_now;
        n_new.level  = r_level;
        n_new.code   = n_code;
        n_new.stream = n_stream;

        n_found  = w_entry[w_scan[ENTRIES].join_idx];

        n_count  = r_count;
        n_status = ST_REJECTED;
        n_slot   = 3'd0;
        n_out    = '0;
        unique case (r_op)
            OP_BEACON: begin
                if (r_ok) begin
                    n_status = ST_STORED;
                    n_slot   = 3'(n_sel);
                    n_out    = n_new;
                    if (n_fresh) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            OP_JOIN: begin
                if (w_scan[ENTRIES].join_hit) begin
                    n_status = ST_FOUND;
                    n_slot   = 3'(w_scan[ENTRIES].join_idx);
                    n_out    = n_found;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: begin
                n_status = ST_CLEARED;
                n_count  = '0;
            end
            OP_NONE: begin
                n_status = ST_REJECTED;
            end
        endcase

        w_wr.we   = (r_state == S_FINISH) && (r_op == OP_BEACON) && r_ok;
        w_wr.clr  = (r_state == S_FINISH) && (r_op == OP_CLEAR);
        w_wr.idx  = n_sel;
        w_wr.data = n_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_scan_done <= 1'b0;
            r_count     <= '0;
            o_valid     <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            o_valid  <= 1'b0;
            if (w_tok[ENTRIES]) begin
                r_scan_done <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // hold the command beat for the whole walk
                        r_query.addr   <= i_src_addr;
                        r_query.room   <= i_room_id;
                        r_query.stream <= i_beacon_stream;
                        r_query.code   <= i_lookup_code;
                        r_op           <= i_op;
                        r_ok           <= w_beacon_ok;
                        r_now          <= i_now_us;
                        r_level        <= i_signal_level;
                        r_launch       <= 1'b1;
                        r_scan_done    <= 1'b0;
                        r_state        <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan_done && !w_fnv_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    o_valid        <= 1'b1;
                    o_status       <= n_status;
                    o_slot         <= n_slot;
                    o_entry_addr   <= n_out.addr;
                    o_entry_room   <= n_out.room;
                    o_entry_code   <= n_out.code;
                    o_entry_stream <= n_out.stream;
                    o_entry_level  <= n_out.level;
                    o_valid_count  <= 4'(n_count);
                    r_count        <= n_count;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/stul_checker.sv
// Port-level checks for the source table core, bound to the top level.
// Depends on stul_pkg and source_table_update_lookup_core.
module stul_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        o_valid,
    input  logic [2:0]  o_status,
    input  logic [31:0] o_entry_code,
    input  logic [31:0] o_entry_stream,
    input  logic [3:0]  o_valid_count
);
    import stul_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted command");

    a_result_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result beat");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_CLEARED)) |-> (o_valid_count == 4'd0))
        else $error("clear left valid entries");

    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == ST_STORED) || (o_status == ST_FOUND)))
        |-> ((o_entry_code != 32'd0) && (o_entry_stream != 32'd0)))
        else $error("entry with zero code or stream");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((ENTRIES > 15) || (o_valid_count <= 4'(ENTRIES))))
        else $error("valid count above table size");

endmodule

bind source_table_update_lookup_core stul_checker u_stul_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_entry_code   (o_entry_code),
    .o_entry_stream (o_entry_stream),
    .o_valid_count  (o_valid_count)
);

FILE: sim/source_table_update_lookup_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the source table core: directed and random beacon, join and clear
// beats, scored against a behavioural table model. Needs stul_pkg and the core RTL only.
module source_table_update_lookup_core_test;
    import stul_pkg::*;

    // Own copies of the beacon and hash constants, so the scoring does not lean on the RTL
    localparam logic [31:0] GOOD_MAGIC   = 32'h44554152;
    localparam logic [7:0]  GOOD_VERSION = 8'h01;
    localparam logic [7:0]  GOOD_KIND    = 8'h01;
    localparam logic [47:0] GOOD_HEADER  = {GOOD_MAGIC, GOOD_VERSION, GOOD_KIND};
    localparam logic [31:0] HASH_OFFSET  = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME   = 32'd16777619;
    localparam logic [31:0] STREAM_SALT  = 32'h9e3779b9;
    localparam int TABLE_SIZE = 8;
    localparam int POOL_SIZE  = 6;

    typedef struct packed {
        logic [1:0]        op;
        logic [47:0]       addr;
        logic [63:0]       room;
        logic [31:0]       stream;
        logic [31:0]       code;
        logic [47:0]       now;
        logic signed [7:0] level;
        logic [47:0]       header;
        logic [15:0]       frame_us;
        logic [15:0]       rate_hz;
        logic [7:0]        frame_size;
        logic [7:0]        flags;
    } t_source_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        slot;
        logic [47:0]       addr;
        logic [63:0]       room;
        logic [31:0]       code;
        logic [31:0]       stream;
        logic signed [7:0] level;
        logic [3:0]        count;
    } t_table_reply;

    // DUT inputs, all known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        i_op = '0;
    logic [47:0]       i_src_addr = '0;
    logic [63:0]       i_room_id = '0;
    logic [31:0]       i_beacon_stream = '0;
    logic [31:0]       i_lookup_code = '0;
    logic [47:0]       i_now_us = '0;
    logic signed [7:0] i_signal_level = '0;
    logic [47:0]       i_header = '0;
    logic [15:0]       i_frame_us = '0;
    logic [15:0]       i_rate_hz = '0;
    logic [7:0]        i_frame_size = '0;
    logic [7:0]        i_beacon_flags = '0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = '0;
    logic [15:0]       i_cfg_data = '0;

    // DUT outputs
    logic              busy;
    logic              o_valid;
    logic [2:0]        o_status;
    logic [2:0]        o_slot;
    logic [47:0]       o_entry_addr;
    logic [63:0]       o_entry_room;
    logic [31:0]       o_entry_code;
    logic [31:0]       o_entry_stream;
    logic signed [7:0] o_entry_level;
    logic [3:0]        o_valid_count;

    // Model of the table and its configuration
    logic        tbl_valid  [TABLE_SIZE];
    logic [47:0] tbl_addr   [TABLE_SIZE];
    logic [63:0] tbl_room   [TABLE_SIZE];
    logic [47:0] tbl_seen   [TABLE_SIZE];
    logic [7:0]  tbl_level  [TABLE_SIZE];
    logic [31:0] tbl_code   [TABLE_SIZE];
    logic [31:0] tbl_stream [TABLE_SIZE];
    logic [15:0] cfg_frame_us  = RST_FRAME_US;
    logic [15:0] cfg_rate_hz   = RST_RATE_HZ;
    logic [7:0]  cfg_frame_len = RST_FRAME_LEN;

    // Replies owed by the core, oldest first
    t_table_reply table_replies_due[$];

    // Stimulus state
    logic [47:0] addr_pool [POOL_SIZE];
    logic [63:0] room_pool [POOL_SIZE];
    logic [47:0] stamp_us = '0;
    int          gap_pct = 31;
    int          err_count = 0;

    source_table_update_lookup_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_src_addr      (i_src_addr),
        .i_room_id       (i_room_id),
        .i_beacon_stream (i_beacon_stream),
        .i_lookup_code   (i_lookup_code),
        .i_now_us        (i_now_us),
        .i_signal_level  (i_signal_level),
        .i_header        (i_header),
        .i_frame_us      (i_frame_us),
        .i_rate_hz       (i_rate_hz),
        .i_frame_size    (i_frame_size),
        .i_beacon_flags  (i_beacon_flags),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_entry_addr    (o_entry_addr),
        .o_entry_room    (o_entry_room),
        .o_entry_code    (o_entry_code),
        .o_entry_stream  (o_entry_stream),
        .o_entry_level   (o_entry_level),
        .o_valid_count   (o_valid_count)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = rand64();
        return w[47:0];
    endfunction

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // FNV-1a over the eight room bytes then the six address bytes, top byte first
    function automatic logic [31:0] fnv_room_code(input logic [63:0] room,
                                                  input logic [47:0] addr);
        logic [111:0] stream_bytes;
        logic [31:0]  h;
        stream_bytes = {room, addr};
        h = HASH_OFFSET;
        for (int b = 13; b >= 0; b--) begin
            h = (h ^ {24'd0, stream_bytes[8*b +: 8]}) * HASH_PRIME;
        end
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

    // Rooms agree up to and including the first zero byte; later bytes do not count
    function automatic logic same_room(input logic [63:0] a, input logic [63:0] b);
        for (int k = 7; k >= 0; k--) begin
            if (a[8*k +: 8] != b[8*k +: 8]) return 1'b0;
            if (a[8*k +: 8] == 8'd0) return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_table_reply entry_reply(input logic [2:0] status, input int idx);
        t_table_reply r;
        r = '0;
        r.status = status;
        r.slot   = idx[2:0];
        r.addr   = tbl_addr[idx];
        r.room   = tbl_room[idx];
        r.code   = tbl_code[idx];
        r.stream = tbl_stream[idx];
        r.level  = tbl_level[idx];
        return r;
    endfunction

    // Apply one command beat to the model table and return the reply it owes
    function automatic t_table_reply update_source_table(input t_source_cmd c);
        t_table_reply r;
        logic        beacon_ok;
        logic [31:0] rc;
        logic [31:0] mixed;
        int          hit;
        int          free_slot;
        int          oldest;
        int          n;
        r = '0;
        r.status = ST_REJECTED;
        case (c.op)
            OP_BEACON: begin
                beacon_ok = c.header == GOOD_HEADER && c.frame_us == cfg_frame_us &&
                            c.rate_hz == cfg_rate_hz && c.frame_size == cfg_frame_len &&
                            c.flags[0];
                if (beacon_ok) begin
                    hit = -1;
                    free_slot = -1;
                    oldest = -1;
                    for (int i = 0; i < TABLE_SIZE; i++) begin
                        if (!tbl_valid[i]) begin
                            if (free_slot < 0) free_slot = i;
                        end else if (tbl_addr[i] == c.addr &&
                                     same_room(tbl_room[i], c.room)) begin
                            hit = i;
                            break;
                        end else if (oldest < 0 || tbl_seen[i] < tbl_seen[oldest]) begin
                            oldest = i;
                        end
                    end
                    if (hit < 0) hit = (free_slot >= 0) ? free_slot : oldest;
                    rc = fnv_room_code(c.room, c.addr);
                    mixed = rc ^ STREAM_SALT;
                    tbl_valid[hit]  = 1'b1;
                    tbl_addr[hit]   = c.addr;
                    tbl_room[hit]   = c.room;
                    tbl_seen[hit]   = c.now;
                    tbl_level[hit]  = c.level;
                    tbl_code[hit]   = rc;
                    tbl_stream[hit] = (c.stream != 32'd0) ? c.stream :
                                      (mixed != 32'd0) ? mixed : 32'd1;
                    r = entry_reply(ST_STORED, hit);
                end
            end
            OP_JOIN: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    if (tbl_valid[i] && (tbl_addr[i] == c.addr || tbl_stream[i] == c.stream ||
                                         tbl_code[i] == c.code)) begin
                        r = entry_reply(ST_FOUND, i);
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        n = 0;
        for (int i = 0; i < TABLE_SIZE; i++) n += tbl_valid[i];
        r.count = n[3:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------

    // Every field random, op included; the base for all other commands
    function automatic t_source_cmd scrambled_cmd();
        t_source_cmd c;
        logic [63:0] w;
        w = rand64();
        c.op         = w[1:0];
        c.addr       = rand48();
        c.room       = rand64();
        c.stream     = $urandom;
        c.code       = $urandom;
        c.now        = rand48();
        c.header     = rand48();
        w = rand64();
        c.frame_us   = w[15:0];
        c.rate_hz    = w[31:16];
        c.frame_size = w[39:32];
        c.flags      = w[47:40];
        c.level      = w[55:48];
        return c;
    endfunction

    // A beacon that passes every check under the current configuration
    function automatic t_source_cmd beacon_of(input logic [47:0] addr, input logic [63:0] room,
                                              input logic [31:0] stream, input logic [47:0] now,
                                              input logic signed [7:0] level);
        t_source_cmd c;
        c = scrambled_cmd();
        c.op         = OP_BEACON;
        c.addr       = addr;
        c.room       = room;
        c.stream     = stream;
        c.now        = now;
        c.level      = level;
        c.header     = GOOD_HEADER;
        c.frame_us   = cfg_frame_us;
        c.rate_hz    = cfg_rate_hz;
        c.frame_size = cfg_frame_len;
        c.flags[0]   = 1'b1;
        return c;
    endfunction

    // Break exactly one of the beacon checks
    function automatic t_source_cmd spoil_beacon(input t_source_cmd c, input int which);
        case (which)
            0: c.header[47:16] ^= ($urandom | 32'd1);
            1: c.header[15:8]  ^= 8'($urandom_range(1, 255));
            2: c.header[7:0]   ^= 8'($urandom_range(1, 255));
            3: c.frame_us      ^= 16'($urandom_range(1, 65535));
            4: c.rate_hz       ^= 16'($urandom_range(1, 65535));
            5: c.frame_size    ^= 8'($urandom_range(1, 255));
            default: c.flags[0] = 1'b0;
        endcase
        return c;
    endfunction

    function automatic t_source_cmd join_of(input logic [47:0] addr, input logic [31:0] stream,
                                            input logic [31:0] code);
        t_source_cmd c;
        c = scrambled_cmd();
        c.op     = OP_JOIN;
        c.addr   = addr;
        c.stream = stream;
        c.code   = code;
        return c;
    endfunction

    // Keep the bytes up to the first zero, scramble the rest: still the same room
    function automatic logic [63:0] room_variant(input logic [63:0] base);
        logic [63:0] keep;
        keep = '1;
        for (int k = 7; k >= 0; k--) begin
            if (base[8*k +: 8] == 8'd0) begin
                keep = ~((64'd1 << (8*k)) - 64'd1);
                break;
            end
        end
        return (base & keep) | (rand64() & ~keep);
    endfunction

    // Mostly a slowly rising clock, so last-seen ties happen; now and then a jump or zero
    function automatic logic [47:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return rand48();
        if (pick < 12) return 48'd0;
        stamp_us += 48'($urandom_range(0, 2));
        return stamp_us;
    endfunction

    function automatic t_source_cmd random_join();
        t_source_cmd c;
        int idx;
        c = join_of(rand48(), $urandom, $urandom);
        if ($urandom_range(0, 4) == 0) c.stream = 32'd0;
        idx = $urandom_range(0, TABLE_SIZE - 1);
        if (tbl_valid[idx] && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
                0: c.addr = tbl_addr[idx];
                1: c.stream = tbl_stream[idx];
                default: c.code = tbl_code[idx];
            endcase
        end else if ($urandom_range(0, 1) == 0) begin
            c.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return c;
    endfunction

    // Mostly well-formed beacons on a small set of sources, so updates, fills and
    // evictions all happen; the rest are joins, spoilt beacons, clears and noise.
    function automatic t_source_cmd random_command();
        t_source_cmd c;
        logic [63:0] room;
        logic [31:0] stream;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            room = room_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 1) == 0) room = room_variant(room);
            stream = ($urandom_range(0, 9) < 3) ? 32'd0 : $urandom;
            c = beacon_of(addr_pool[$urandom_range(0, POOL_SIZE - 1)], room, stream,
                          next_stamp(), 8'($urandom));
            if (pick >= 52) c = spoil_beacon(c, $urandom_range(0, 6));
        end else if (pick < 92) begin
            c = random_join();
        end else if (pick < 94) begin
            c = scrambled_cmd();
            c.op = OP_CLEAR;
        end else begin
            c = scrambled_cmd();
        end
        return c;
    endfunction

    function automatic void refresh_pools();
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = rand48();
            room_pool[i] = rand64();
            if ($urandom_range(0, 9) < 6) room_pool[i][8*$urandom_range(0, 7) +: 8] = 8'd0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one command beat and hold it until the core takes it. start is left high
    // on return; settle_table drops it, and the next call does so only when it inserts a gap.
    task automatic issue(input t_source_cmd c);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_op            <= c.op;
        i_src_addr      <= c.addr;
        i_room_id       <= c.room;
        i_beacon_stream <= c.stream;
        i_lookup_code   <= c.code;
        i_now_us        <= c.now;
        i_signal_level  <= c.level;
        i_header        <= c.header;
        i_frame_us      <= c.frame_us;
        i_rate_hz       <= c.rate_hz;
        i_frame_size    <= c.frame_size;
        i_beacon_flags  <= c.flags;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        table_replies_due.push_back(update_source_table(c));
    endtask

    // Drop start and wait for every owed reply; every beat owes exactly one
    task automatic settle_table();
        start <= 1'b0;
        while (table_replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; call only when the core is idle
    task automatic set_config(input logic [15:0] frame_us, input logic [15:0] rate_hz,
                              input logic [15:0] frame_len);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_US;
        i_cfg_data <= frame_us;
        @(posedge i_clk);
        i_cfg_idx  <= REG_RATE_HZ;
        i_cfg_data <= rate_hz;
        @(posedge i_clk);
        i_cfg_idx  <= REG_FRAME_LEN;
        i_cfg_data <= frame_len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_frame_us  = frame_us;
        cfg_rate_hz   = rate_hz;
        cfg_frame_len = frame_len[7:0];
    endtask

    // ------------------------------------------------------------------
    // Reply scoreboard
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // Take each reply beat at the edge that closes its strobe cycle
    always @(posedge i_clk) begin : score_reply
        t_table_reply want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (table_replies_due.size() == 0) begin
                $error("reply beat with none owed: status %0d slot %0d", o_status, o_slot);
                err_count++;
            end else begin
                want = table_replies_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot", want.slot, o_slot);
                check_field("entry_addr", want.addr, o_entry_addr);
                check_field("entry_room", want.room, o_entry_room);
                check_field("entry_code", want.code, o_entry_code);
                check_field("entry_stream", want.stream, o_entry_stream);
                check_field("entry_level", want.level, o_entry_level);
                check_field("valid_count", want.count, o_valid_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // A join against the empty table after reset finds nothing
    task automatic test_empty_lookup();
        issue(join_of(rand48(), $urandom, $urandom));
        issue(join_of(48'd0, 32'd0, 32'd0));
        settle_table();
    endtask

    // All-zero beacon (zero time stamp, derived stream id, lowest level) then all-ones beacon
    task automatic test_beacon_extremes();
        issue(beacon_of(48'd0, 64'd0, 32'd0, 48'd0, 8'sh80));
        issue(beacon_of('1, '1, '1, '1, 8'sh7F));
        settle_table();
    endtask

    // Each header, config and flag check fails on its own; op 3 is refused like a bad beacon
    task automatic test_beacon_rejects();
        t_source_cmd c;
        for (int k = 0; k < 7; k++) begin
            issue(spoil_beacon(beacon_of(rand48(), rand64(), $urandom, rand48(), 8'($urandom)), k));
        end
        c = beacon_of(rand48(), rand64(), $urandom, rand48(), 8'($urandom));
        c.op = OP_NONE;
        issue(c);
        settle_table();
    endtask

    // Bytes after the first zero of the room id do not split an entry; a change to that zero byte does
    task automatic test_room_prefix_update();
        logic [47:0] addr;
        addr = rand48();
        issue(beacon_of(addr, 64'h5253_00_1122334455, 32'd0, 48'd100, 8'sd10));
        issue(beacon_of(addr, 64'h5253_00_AABBCCDDEE, $urandom, 48'd200, -8'sd20));
        issue(beacon_of(addr, 64'h5253_01_AABBCCDDEE, 32'd0, 48'd300, -8'sd30));
        settle_table();
    endtask

    // Joins by address, by stream id and by room code; stream zero only hits by the others;
    // several candidates give the lowest slot
    task automatic test_join_lookup();
        issue(join_of(tbl_addr[2], $urandom | 32'd1, $urandom));
        issue(join_of(rand48(), tbl_stream[3], $urandom));
        issue(join_of(rand48(), $urandom | 32'd1, tbl_code[1]));
        issue(join_of(rand48() | 48'd1, 32'd0, $urandom));
        issue(join_of(48'd0, 32'd0, $urandom));
        issue(join_of(tbl_addr[3], $urandom | 32'd1, tbl_code[1]));
        settle_table();
    endtask

    // Clear empties the table; a former entry is gone afterwards
    task automatic test_clear();
        t_source_cmd c;
        c = scrambled_cmd();
        c.op = OP_CLEAR;
        issue(c);
        issue(join_of(tbl_addr[2], tbl_stream[2], tbl_code[2]));
        settle_table();
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    task automatic run_traffic(input int beats, input int idle_pct);
        gap_pct = idle_pct;
        refresh_pools();
        for (int n = 0; n < beats; n++) issue(random_command());
        settle_table();
    endtask

    task automatic test_traffic_default_config();
        run_traffic(500, 31);
    endtask

    task automatic test_traffic_config_floor();
        set_config(16'd0, 16'd0, 16'd0);
        run_traffic(350, 31);
    endtask

    task automatic test_traffic_config_ceiling();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(350, 31);
    endtask

    // Random settings, upper bits of the byte register junk; no sender gaps at all
    task automatic test_traffic_random_config();
        set_config(16'($urandom), 16'($urandom), 16'($urandom));
        run_traffic(400, 0);
    endtask

    task automatic test_traffic_back_to_defaults();
        set_config(RST_FRAME_US, RST_RATE_HZ, {8'($urandom), RST_FRAME_LEN});
        run_traffic(300, 31);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) tbl_valid[i] = 1'b0;
        // hold reset low from time zero, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookup();
        test_beacon_extremes();
        test_beacon_rejects();
        test_room_prefix_update();
        test_join_lookup();
        test_clear();
        test_traffic_default_config();
        test_traffic_config_floor();
        test_traffic_config_ceiling();
        test_traffic_random_config();
        test_traffic_back_to_defaults();

        // let any stray late beat show up before the verdict
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[source_table_update_lookup_core] OK");
        end else begin
            $display("[source_table_update_lookup_core] ERROR");
        end
        $finish;
    end

    // Hang guard: several times the slowest legal run
    initial begin
        #8_000_000;
        $display("[source_table_update_lookup_core] ERROR");
        $finish;
    end

endmodule
